>>> sv/kslift_pkg.sv
// Shared types and constants for the k-th successor binary lifting block.
`default_nettype none

package kslift_pkg;

	localparam int NODE_W = 10;
	localparam int DIST_W = 26;
	// Highest distance bit; the walk starts here.
	localparam int DIST_TOP = 25;
	localparam int POS_W = $clog2(DIST_W);

	typedef enum logic [1:0] {
		KIND_SET   = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] successor;
		logic [DIST_W-1:0] distance;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] answer;
		logic              status;
	} rsp_t;

endpackage

`default_nettype wire

>>> sv/kth_successor_binary_lifting.sv
// K-th successor engine: successor store, binary lifting jump table and query walker.
`default_nettype none

// Answers k-th successor queries on a graph where every node has one successor.
// A request transaction of kind set writes one successor (node zero is refused with
// status 1), kind build fills the jump table level by level, and kind query walks
// the distance bits from the top down through that table; every request gives one
// response transaction. All work runs on one read port and one write port of each
// memory under a small sequencer, one request at a time, so req_ready is high only
// when the sequencer is idle. A build covers nodes 1 to lim, where lim is the smaller of
// node_count and NODE_COUNT_MAX-1. After reset the successor store is cleared in a pass
// over all NODE_COUNT_MAX entries, one entry per cycle, during which no request is taken
// (configuration writes are). Table entries of node zero and of nodes above lim are never
// stored; lookups of them are forced to zero against the lim captured at the last build.
module kth_successor_binary_lifting
	import kslift_pkg::*;
#(
	parameter int NODE_COUNT_MAX = 1024,
	parameter int LEVELS = 26
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output rsp_t              rsp,
	input  wire               cfg_we,
	input  wire  [NODE_W-1:0] cfg_wdata
);

	localparam int NW = $clog2(NODE_COUNT_MAX);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_BLD_RD = 8'b0000_0100,
		S_BLD_MD = 8'b0000_1000,
		S_BLD_WR = 8'b0001_0000,
		S_Q_BIT  = 8'b0010_0000,
		S_Q_WAIT = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	function automatic logic [NW-1:0] to_idx(input logic [NODE_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[NW-1:0];
	endfunction

	state_t state_q;

	logic [NODE_W-1:0] node_count_q;
	logic [NODE_W-1:0] lim_q;     // highest node covered by the last build
	logic [NW-1:0]     clr_q;
	logic [LW-1:0]     lvl_q;
	logic [NW-1:0]     idx_q;
	logic [POS_W-1:0]  pos_q;
	logic [DIST_W-1:0] dist_q;
	logic [NODE_W-1:0] cur_q;
	logic              stat_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// Memories
	logic [NODE_W-1:0] st_mem [NODE_COUNT_MAX];
	logic [NODE_W-1:0] jt_mem [LEVELS][NODE_COUNT_MAX];
	logic [NODE_W-1:0] st_rd_q;
	logic [NODE_W-1:0] jt_rd_q;

	logic              st_we;
	logic [NW-1:0]     st_wn;
	logic [NODE_W-1:0] st_wd;
	logic              jt_we;
	logic [LW-1:0]     jt_wl;
	logic [NW-1:0]     jt_wn;
	logic [NODE_W-1:0] jt_wd;
	logic [LW-1:0]     jt_rl;
	logic [NW-1:0]     jt_rn;

	logic              req_fire;
	logic [NODE_W-1:0] lim_d;
	logic [LW-1:0]     lvl_prev;
	logic [LW-1:0]     pos_lvl;
	logic [31:0]       pos_w;
	logic              pos_live;
	logic              rd_live;
	logic              cur_live;
	logic              adv;
	logic              idx_last;
	logic              lvl_last;
	logic              rsp_free;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// Build range: never past the last store entry.
	assign lim_d = (32'(node_count_q) > NODE_COUNT_MAX - 1) ?
		NODE_W'(NODE_COUNT_MAX - 1) : node_count_q;

	assign lvl_prev = lvl_q - 1'b1;
	assign pos_w    = 32'(pos_q);
	assign pos_lvl  = pos_w[LW-1:0];
	assign pos_live = dist_q[pos_q] && (pos_w < LEVELS);

	// A lookup yields a stored entry only for nodes 1..lim_q.
	assign rd_live  = (jt_rd_q != '0) && (jt_rd_q <= lim_q);
	assign cur_live = (cur_q != '0) && (cur_q <= lim_q);

	assign idx_last = (32'(idx_q) == 32'(lim_q));
	assign lvl_last = (32'(lvl_q) == LEVELS - 1);
	assign adv = ((state_q == S_BLD_MD) && ((lvl_q == '0) || !rd_live)) ||
		(state_q == S_BLD_WR);

	// Memory port steering
	always_comb begin
		st_we = 1'b0;
		st_wn = clr_q;
		st_wd = '0;
		if (state_q == S_CLEAR) begin
			st_we = 1'b1;
		end else if (req_fire && (req.kind == KIND_SET) && (req.node != '0) &&
			(32'(req.node) < NODE_COUNT_MAX)) begin
			st_we = 1'b1;
			st_wn = to_idx(req.node);
			st_wd = req.successor;
		end
	end

	always_comb begin
		jt_we = 1'b0;
		jt_wl = lvl_q;
		jt_wn = idx_q;
		jt_wd = '0;
		jt_rl = lvl_prev;
		jt_rn = idx_q;
		unique case (state_q)
			S_BLD_MD: begin
				jt_rn = to_idx(jt_rd_q);
				if (lvl_q == '0) begin
					jt_we = 1'b1;
					jt_wd = st_rd_q;
				end else if (!rd_live) begin
					jt_we = 1'b1;
				end
			end
			S_BLD_WR: begin
				jt_we = 1'b1;
				jt_wd = jt_rd_q;
			end
			S_Q_BIT: begin
				jt_rl = pos_lvl;
				jt_rn = to_idx(cur_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wn] <= st_wd;
		end
		st_rd_q <= st_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (jt_we) begin
			jt_mem[jt_wl][jt_wn] <= jt_wd;
		end
		jt_rd_q <= jt_mem[jt_rl][jt_rn];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			lim_q   <= '0;
			lvl_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			dist_q  <= '0;
			cur_q   <= '0;
			stat_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NODE_COUNT_MAX - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						cur_q  <= '0;
						stat_q <= 1'b0;
						state_q <= S_DONE;
						unique case (req.kind)
							KIND_SET: begin
								stat_q <= (req.node == '0);
							end
							KIND_BUILD: begin
								lim_q <= lim_d;
								lvl_q <= '0;
								idx_q <= NW'(1);
								if (lim_d != '0) begin
									state_q <= S_BLD_RD;
								end
							end
							KIND_QUERY: begin
								cur_q   <= req.node;
								dist_q  <= req.distance;
								pos_q   <= POS_W'(DIST_TOP);
								state_q <= S_Q_BIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_BLD_RD: begin
					state_q <= S_BLD_MD;
				end
				S_BLD_MD, S_BLD_WR: begin
					if (adv) begin
						state_q <= S_BLD_RD;
						if (idx_last) begin
							idx_q <= NW'(1);
							if (lvl_last) begin
								state_q <= S_DONE;
							end else begin
								lvl_q <= lvl_q + 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						// second lookup issued this cycle
						state_q <= S_BLD_WR;
					end
				end
				S_Q_BIT: begin
					if (pos_live && cur_live) begin
						state_q <= S_Q_WAIT;
					end else begin
						if (pos_live) begin
							cur_q <= '0;
						end
						if (pos_q == '0) begin
							state_q <= S_DONE;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				S_Q_WAIT: begin
					cur_q <= jt_rd_q;
					if (pos_q == '0) begin
						state_q <= S_DONE;
					end else begin
						pos_q   <= pos_q - 1'b1;
						state_q <= S_Q_BIT;
					end
				end
				S_DONE: begin
					// hold until the output register frees up
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: decouples the sequencer from a stalled consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_q.answer <= cur_q;
			rsp_q.status <= stat_q;
		end
	end

	// Checks
	a_jt_no_node0: assert property (@(posedge clk) disable iff (!arst_n)
		jt_we |-> (jt_wn != '0))
		else $error("jump table written at node zero");

	a_jt_in_lim: assert property (@(posedge clk) disable iff (!arst_n)
		jt_we |-> (32'(jt_wn) <= 32'(lim_q)))
		else $error("jump table written above build limit");

	a_st_node0_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && (st_wn == '0)) |-> (state_q == S_CLEAR))
		else $error("successor store node zero written outside clear pass");

	a_q_wait_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_WAIT) |-> ($past(state_q) == S_Q_BIT))
		else $error("query wait without a lookup");

	a_bld_wr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BLD_WR) |-> ($past(state_q) == S_BLD_MD) && (lvl_q != '0))
		else $error("build write without second lookup");

endmodule

`default_nettype wire
